// ===== hdl/saf_pkg.sv =====
// ----------------------------------------------------------------------------
// saf_pkg: shared types and constants of the swap frame allocator
// Frame and offset widths, command and status codes, queue word type.
// ----------------------------------------------------------------------------
package saf_pkg;

    localparam int PAGES     = 1024;
    localparam int RESERVE   = 10;
    localparam int FREE_INIT = PAGES - RESERVE;
    localparam int AW        = $clog2(PAGES);
    localparam int FW        = 10;

    // input command codes
    localparam logic [1:0] CMD_MAP    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;

    typedef enum logic [1:0] {
        OP_MAP,
        OP_LOOKUP,
        OP_FREE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOFREE       = 2'd1,
        ST_UNMAPPED     = 2'd2,
        ST_FREE_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC
    } t_bstate;

    typedef struct packed {
        t_op           op;
        logic [FW-1:0] offset;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

// ===== hdl/saf_front.sv =====
// ----------------------------------------------------------------------------
// saf_front: command intake
// Accepts commands, classifies the command code and queues the word for the
// execution side in a two-entry queue.
// ----------------------------------------------------------------------------
module saf_front
    import saf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [1:0]    i_cmd,
    input  logic [FW-1:0] i_offset,
    input  logic          i_hold,
    input  logic          i_pop,
    output logic          busy,
    output t_qhead        o_head
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    t_cmd             r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;
    t_cmd             w_word;

    assign busy   = i_hold || (r_cnt == QCW'(QDEPTH));
    assign w_push = start && !busy;
    assign w_pop  = i_pop && (r_cnt != '0);

    // classify: code 3 acts as a lookup
    always_comb begin
        w_word.offset = i_offset;
        case (i_cmd)
            CMD_MAP:  w_word.op = OP_MAP;
            CMD_FREE: w_word.op = OP_FREE;
            default:  w_word.op = OP_LOOKUP;
        endcase
    end

    always_comb begin
        n_wp  = w_push ? r_wp + QAW'(1) : r_wp;
        n_rp  = w_pop  ? r_rp + QAW'(1) : r_rp;
        n_cnt = r_cnt + QCW'(w_push) - QCW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_word;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

// ===== hdl/saf_back.sv =====
// ----------------------------------------------------------------------------
// saf_back: command execution
// Holds the slot map and the free ring, runs the clearing pass after reset,
// and executes one queued word at a time: read, then update and report.
// ----------------------------------------------------------------------------
module saf_back
    import saf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qhead        i_head,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_strobe,
    output logic [FW-1:0] o_frame,
    output logic [1:0]    o_status,
    output logic [FW-1:0] o_mapped_count,
    output logic [FW-1:0] o_free_count
);

    logic [FW-1:0] slot_map  [PAGES];
    logic [FW-1:0] free_ring [PAGES];

    t_bstate       r_state, n_state;
    logic [AW-1:0] r_clr_idx, n_clr_idx;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_mapped, n_mapped;
    t_cmd          r_cmd;
    logic [FW-1:0] r_map_q;
    logic [FW-1:0] r_ring_q;

    logic          r_strobe, n_strobe;
    logic [FW-1:0] r_frame, n_frame;
    t_status       r_status, n_status;
    logic [FW-1:0] r_mcount;
    logic [FW-1:0] r_fcount;

    logic          w_rd_en;
    logic          w_map_we;
    logic [AW-1:0] w_map_wa;
    logic [FW-1:0] w_map_wd;
    logic          w_ring_we;
    logic [AW-1:0] w_ring_wa;
    logic [FW-1:0] w_ring_wd;
    logic [AW-1:0] w_len;

    // ring length wraps naturally with a power-of-two depth
    assign w_len = r_tail - r_head;

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_head    = r_head;
        n_tail    = r_tail;
        n_mapped  = r_mapped;
        n_strobe  = 1'b0;
        n_frame   = '0;
        n_status  = ST_OK;
        w_rd_en   = 1'b0;
        w_map_we  = 1'b0;
        w_map_wa  = r_cmd.offset[AW-1:0];
        w_map_wd  = '0;
        w_ring_we = 1'b0;
        w_ring_wa = r_tail;
        w_ring_wd = r_map_q;
        case (r_state)
            BS_CLEAR: begin
                w_map_we  = 1'b1;
                w_map_wa  = r_clr_idx;
                w_ring_we = 1'b1;
                w_ring_wa = r_clr_idx;
                w_ring_wd = (32'(r_clr_idx) < FREE_INIT) ?
                            FW'(r_clr_idx) + FW'(1) : '0;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(PAGES - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_head.valid) begin
                    w_rd_en = 1'b1;
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                n_strobe = 1'b1;
                n_state  = BS_IDLE;
                case (r_cmd.op)
                    OP_MAP: begin
                        if (r_map_q != '0) begin
                            n_frame = r_map_q;
                        end else if (w_len == '0) begin
                            n_status = ST_NOFREE;
                        end else begin
                            n_frame  = r_ring_q;
                            n_head   = r_head + AW'(1);
                            w_map_we = 1'b1;
                            w_map_wd = r_ring_q;
                            n_mapped = r_mapped + FW'(1);
                        end
                    end
                    OP_FREE: begin
                        if (r_map_q == '0) begin
                            n_status = ST_FREE_IGNORED;
                        end else begin
                            n_frame  = r_map_q;
                            // drop the frame if the ring is full
                            if (w_len != AW'(PAGES - 1)) begin
                                w_ring_we = 1'b1;
                                n_tail    = r_tail + AW'(1);
                            end
                            w_map_we = 1'b1;
                            if (r_mapped != '0) begin
                                n_mapped = r_mapped - FW'(1);
                            end
                        end
                    end
                    default: begin
                        if (r_map_q == '0) begin
                            n_status = ST_UNMAPPED;
                        end else begin
                            n_frame = r_map_q;
                        end
                    end
                endcase
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_CLEAR;
            r_clr_idx <= '0;
            r_head    <= '0;
            r_tail    <= AW'(FREE_INIT);
            r_mapped  <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_mapped  <= n_mapped;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_cmd <= i_head.cmd;
        end
        if (n_strobe) begin
            r_frame  <= n_frame;
            r_status <= n_status;
            r_mcount <= n_mapped;
            r_fcount <= FW'(n_tail - n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_map_q <= slot_map[i_head.cmd.offset[AW-1:0]];
        end
        if (w_map_we) begin
            slot_map[w_map_wa] <= w_map_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_ring_q <= free_ring[r_head];
        end
        if (w_ring_we) begin
            free_ring[w_ring_wa] <= w_ring_wd;
        end
    end

    assign o_pop          = w_rd_en;
    assign o_clearing     = (r_state == BS_CLEAR);
    assign o_strobe       = r_strobe;
    assign o_frame        = r_frame;
    assign o_status       = r_status;
    assign o_mapped_count = r_mcount;
    assign o_free_count   = r_fcount;

endmodule

// ===== hdl/swap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// swap_frame_allocator: swap offset to page frame map with a free frame ring
// Map, lookup and free commands over 1024 offsets and a ring of free frames.
// ----------------------------------------------------------------------------
// After reset busy stays high while the slot map and the free ring are
// initialized one entry a cycle. A command is taken when start is high and
// busy is low, and goes into a two-entry queue; busy also rises when that
// queue is full. The execution unit takes one command at a time (slot map
// and ring read, then update and write-back) and reads the next only after
// the last is reported. The single result of a command follows the command
// and read registers, on o_strobe for exactly one cycle; the receiver cannot
// stall, so it must take every word when strobed.
module swap_frame_allocator
    import saf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    i_cmd,
    input  logic [FW-1:0] i_offset,
    output logic          o_strobe,
    output logic [FW-1:0] o_frame,
    output logic [1:0]    o_status,
    output logic [FW-1:0] o_mapped_count,
    output logic [FW-1:0] o_free_count
);

    t_qhead w_head;
    logic   w_pop;
    logic   w_clearing;

    saf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_offset (i_offset),
        .i_hold   (w_clearing),
        .i_pop    (w_pop),
        .busy     (busy),
        .o_head   (w_head)
    );

    saf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_clearing     (w_clearing),
        .o_strobe       (o_strobe),
        .o_frame        (o_frame),
        .o_status       (o_status),
        .o_mapped_count (o_mapped_count),
        .o_free_count   (o_free_count)
    );

    // execution through the idle state never strobes twice in a row
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe on consecutive cycles");

    // a failed command reports no frame
    a_err_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> (o_frame == '0))
        else $error("frame reported with error status");

    // every frame is either mapped or waiting in the ring
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((32'(o_mapped_count) + 32'(o_free_count)) == FREE_INIT))
        else $error("frame count not conserved");

    // no result while initialization is still running
    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_strobe && !w_pop)
        else $error("activity during initialization");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the swap frame allocator
// Drives map, lookup and free commands, predicts every result word from a
// model of the slot map and the free ring, and checks each strobed word.
// ----------------------------------------------------------------------------
module tb;
    import saf_pkg::*;

    localparam int          LIMIT_CYCLES     = 40000;
    localparam int          DRAIN_CYCLES     = 12;
    // command code 3 is taken as a lookup
    localparam logic [1:0]  CMD_ALIAS_LOOKUP = 2'd3;

    typedef struct {
        logic [FW-1:0] frame;
        t_status       status;
        logic [FW-1:0] mapped;
        logic [FW-1:0] free;
    } t_swap_word;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [1:0]    i_cmd;
    logic [FW-1:0] i_offset;
    logic          o_strobe;
    logic [FW-1:0] o_frame;
    logic [1:0]    o_status;
    logic [FW-1:0] o_mapped_count;
    logic [FW-1:0] o_free_count;

    // predicted allocator state
    logic [FW-1:0] slot_frame [PAGES];
    logic [FW-1:0] free_frames [PAGES];
    logic [AW-1:0] ring_rd;
    logic [AW-1:0] ring_wr;
    logic [FW-1:0] live_maps;

    t_swap_word    pending_words [$];
    int            idle_pct;
    int            fail_count;
    int            cycle_count;

    swap_frame_allocator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_offset       (i_offset),
        .o_strobe       (o_strobe),
        .o_frame        (o_frame),
        .o_status       (o_status),
        .o_mapped_count (o_mapped_count),
        .o_free_count   (o_free_count)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [FW-1:0] ring_fill();
        logic [AW-1:0] len;
        len = ring_wr - ring_rd;
        return FW'(len);
    endfunction

    // work out the result word of one accepted command and queue it
    function automatic void apply_swap_cmd(input logic [1:0] cmd, input logic [FW-1:0] off);
        t_swap_word    w;
        logic [FW-1:0] cur;
        cur      = slot_frame[off];
        w.frame  = '0;
        w.status = ST_OK;
        case (cmd)
            CMD_MAP: begin
                if (cur != '0) begin
                    w.frame = cur;
                end else if (ring_fill() == '0) begin
                    w.status = ST_NOFREE;
                end else begin
                    w.frame              = free_frames[ring_rd];
                    free_frames[ring_rd] = '0;
                    ring_rd              = ring_rd + AW'(1);
                    slot_frame[off]      = w.frame;
                    live_maps            = live_maps + FW'(1);
                end
            end
            CMD_FREE: begin
                if (cur == '0) begin
                    w.status = ST_FREE_IGNORED;
                end else begin
                    w.frame = cur;
                    // drop the frame if the ring were ever full
                    if (ring_fill() < FW'(PAGES - 1)) begin
                        free_frames[ring_wr] = cur;
                        ring_wr              = ring_wr + AW'(1);
                    end
                    slot_frame[off] = '0;
                    if (live_maps != '0) live_maps = live_maps - FW'(1);
                end
            end
            default: begin
                if (cur == '0) w.status = ST_UNMAPPED;
                else           w.frame  = cur;
            end
        endcase
        w.mapped = live_maps;
        w.free   = ring_fill();
        pending_words.push_back(w);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (fail_count < 100)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : check_words
        t_swap_word want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_words.size() == 0) begin
                flag_mismatch("unexpected word, frame", int'(o_frame), 0);
            end else begin
                want = pending_words.pop_front();
                if (o_frame !== want.frame)
                    flag_mismatch("frame", int'(o_frame), int'(want.frame));
                if (o_status !== want.status)
                    flag_mismatch("status", int'(o_status), int'(want.status));
                if (o_mapped_count !== want.mapped)
                    flag_mismatch("mapped_count", int'(o_mapped_count), int'(want.mapped));
                if (o_free_count !== want.free)
                    flag_mismatch("free_count", int'(o_free_count), int'(want.free));
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] cmd, input logic [FW-1:0] off);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_cmd    <= cmd;
        i_offset <= off;
        do @(posedge i_clk); while (busy);
        apply_swap_cmd(cmd, off);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        send_word(CMD_MAP, 10'd0);
        send_word(CMD_MAP, 10'd1023);
        send_word(CMD_MAP, 10'd0);          // already mapped: no allocation
        send_word(CMD_LOOKUP, 10'd0);
        send_word(CMD_LOOKUP, 10'd1023);
        send_word(CMD_LOOKUP, 10'd512);     // unmapped
        send_word(CMD_ALIAS_LOOKUP, 10'd0);
        send_word(CMD_ALIAS_LOOKUP, 10'd511);
        send_word(CMD_FREE, 10'd0);
        send_word(CMD_FREE, 10'd0);         // free of unmapped
        send_word(CMD_LOOKUP, 10'd0);
        send_word(CMD_MAP, 10'd0);
        send_word(CMD_MAP, 10'h2AA);
        send_word(CMD_MAP, 10'h155);
        send_word(CMD_LOOKUP, 10'h2AA);
        send_word(CMD_FREE, 10'h155);
        send_word(CMD_FREE, 10'd1023);
        send_word(CMD_MAP, 10'h155);
        send_word(CMD_FREE, 10'h2AA);
        send_word(CMD_FREE, 10'd700);
        send_word(CMD_LOOKUP, 10'h155);
    endtask

    task automatic test_random_traffic(input int n_words, input int idle);
        logic [1:0]    cmd;
        logic [FW-1:0] off;
        int            pick;
        idle_pct = idle;
        repeat (n_words) begin
            pick = $urandom_range(99);
            if (pick < 40)      cmd = CMD_MAP;
            else if (pick < 60) cmd = CMD_LOOKUP;
            else if (pick < 95) cmd = CMD_FREE;
            else                cmd = CMD_ALIAS_LOOKUP;
            // keep most offsets in a small pool so frees and lookups hit
            if ($urandom_range(99) < 75) off = FW'($urandom_range(47));
            else                         off = FW'($urandom_range(PAGES - 1));
            send_word(cmd, off);
        end
    endtask

    // map a block of offsets, look up random offsets, then release the block in reverse order
    task automatic test_block_sweep(input int n_block, input int idle);
        idle_pct = idle;
        for (int i = 0; i < n_block; i++) send_word(CMD_MAP, FW'(512 + i));
        repeat (4)  send_word(CMD_MAP, FW'($urandom_range(PAGES - 1)));
        repeat (16) send_word(CMD_LOOKUP, FW'($urandom_range(PAGES - 1)));
        for (int i = n_block - 1; i >= 0; i--) send_word(CMD_FREE, FW'(512 + i));
        repeat (3)  send_word(CMD_FREE, FW'($urandom_range(PAGES - 1)));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = CMD_MAP;
        i_offset    = '0;
        idle_pct    = 0;
        fail_count  = 0;
        cycle_count = 0;
        ring_rd     = '0;
        ring_wr     = AW'(FREE_INIT);
        live_maps   = '0;
        for (int i = 0; i < PAGES; i++) begin
            slot_frame[i]  = '0;
            free_frames[i] = (i < FREE_INIT) ? FW'(i + 1) : '0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_traffic(150, 0);
        test_block_sweep(100, 30);
        test_random_traffic(100, 62);
        test_random_traffic(100, 30);
        test_random_traffic(60, 0);

        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
